/* rtl/dhs_pkg.sv */
// shared types and constants for the duration histogram statistics block
// no dependencies
package dhs_pkg;

  localparam int NUM_BUCKETS = 8;
  localparam int NUM_BOUNDS  = 7;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int CFG_IDX_W   = 3;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // one input item
  typedef struct packed {
    op_t         operation;
    logic [31:0] timestamp_us;
    logic [2:0]  bucket_index;
  } in_t;

  // classified event handed from front to back
  typedef struct packed {
    logic        rec_run;
    logic        rec_wait;
    logic [31:0] dur;
    logic [2:0]  sel;
  } evt_t;

  typedef struct packed {
    logic [31:0] run_count;
    logic [31:0] run_sum;
    logic [31:0] run_min;
    logic [31:0] run_max;
    logic [31:0] run_median;
    logic [31:0] wait_sum;
    logic [31:0] wait_min;
    logic [31:0] wait_max;
    logic [31:0] wait_median;
    logic [31:0] run_bucket_count;
    logic [31:0] wait_bucket_count;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BKT, ST_REC, ST_MED_INIT, ST_MED_SCAN, ST_MED_MUL,
    ST_MED_DIV, ST_MED_DONE, ST_OUT
  } bst_t;

endpackage

/* rtl/dhs_if.sv */
// valid/ready channel carrying one item of type T
// no dependencies
interface dhs_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dhs_front.sv */
// front: accepts events, keeps timestamps, computes the duration to record
// depends on dhs_pkg
module dhs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic [31:0]      in_ts,
  input  logic [2:0]       in_sel,
  output logic             q_push,
  output dhs_pkg::evt_t    q_data,
  input  logic             q_full
);
  import dhs_pkg::*;

  logic [31:0] start_time, end_time;
  logic        end_seen;
  logic        acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc;

  always_comb begin
    q_data.sel      = in_sel;
    q_data.rec_run  = (in_op == OP_END);
    q_data.rec_wait = (in_op == OP_BEGIN) && end_seen;
    q_data.dur      = (in_op == OP_END) ? in_ts - start_time : in_ts - end_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      end_time   <= '0;
      end_seen   <= 1'b0;
    end else if (acc) begin
      if (in_op == OP_BEGIN) start_time <= in_ts;
      if (in_op == OP_END) begin
        end_time <= in_ts;
        end_seen <= 1'b1;
      end
    end
  end
endmodule

/* rtl/dhs_queue.sv */
// two entry fifo between front and back
// depends on dhs_pkg
module dhs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dhs_pkg::evt_t wdata,
  output logic          full,
  input  logic          pop,
  output dhs_pkg::evt_t rdata,
  output logic          nonempty
);
  import dhs_pkg::*;

  evt_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign nonempty = (cnt != 2'd0);
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/dhs_back.sv */
// back: bucket walk, statistics update, median by scan, multiply and divide
// depends on dhs_pkg
module dhs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  logic                q_nonempty,
  input  dhs_pkg::evt_t       q_data,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output dhs_pkg::res_t       res_data
);
  import dhs_pkg::*;

  bst_t state, state_next;

  logic [31:0] bounds [NUM_BOUNDS];
  logic [31:0] rhist [NUM_BUCKETS];
  logic [31:0] whist [NUM_BUCKETS];
  logic [31:0] rmin, rmax, rsum, wmin, wmax, wsum, runs, waits;

  evt_t        ev;
  logic [BKT_W-1:0] k;
  logic        phase;   // 0 run median, 1 wait median
  logic [31:0] cnt_m, m;
  logic [32:0] upper, lower;
  logic [31:0] lo, hi, den, med, run_med;
  logic [63:0] prod, rem_q;
  logic [32:0] rem;
  logic [5:0]  step;
  logic [31:0] smin, smax;
  logic [31:0] hk;

  function automatic logic [31:0] bnd(input logic [BKT_W-1:0] i);
    if (32'(i) + 1 >= NUM_BUCKETS) return ALL_ONES;
    return bounds[i[2:0]];
  endfunction

  assign smin = phase ? wmin : rmin;
  assign smax = phase ? wmax : rmax;
  assign cnt_m = phase ? waits : runs;
  assign hk = phase ? whist[k] : rhist[k];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (q_nonempty) state_next = ST_BKT;
      ST_BKT:      if (!(ev.rec_run || ev.rec_wait) || 32'(k) + 1 >= NUM_BUCKETS ||
                       bnd(k) >= ev.dur) state_next = ST_REC;
      ST_REC:      state_next = ST_MED_INIT;
      ST_MED_INIT: state_next = (cnt_m <= 32'd2) ? ST_MED_DONE : ST_MED_SCAN;
      ST_MED_SCAN: if (upper + {1'b0, hk} >= {1'b0, m} || 32'(k) + 1 >= NUM_BUCKETS)
                     state_next = ST_MED_MUL;
      ST_MED_MUL:  state_next = (den == 0 || hi <= lo || {1'b0, m} <= lower) ?
                                ST_MED_DONE : ST_MED_DIV;
      ST_MED_DIV:  if (step == 6'd63) state_next = ST_MED_DONE;
      ST_MED_DONE: state_next = phase ? ST_OUT : ST_MED_INIT;
      ST_OUT:      if (res_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == ST_IDLE) && q_nonempty;
    res_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds[0] <= 32'd10;    bounds[1] <= 32'd100;   bounds[2] <= 32'd500;
      bounds[3] <= 32'd1000;  bounds[4] <= 32'd5000;  bounds[5] <= 32'd10000;
      bounds[6] <= 32'd100000;
    end else if (cfg_we && cfg_idx < 3'(NUM_BOUNDS)) begin
      bounds[cfg_idx] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        rhist[i] <= '0; whist[i] <= '0;
      end
      rmin <= ALL_ONES; rmax <= '0; rsum <= '0;
      wmin <= ALL_ONES; wmax <= '0; wsum <= '0;
      runs <= '0; waits <= '0;
    end else if (state == ST_REC) begin
      if (ev.rec_run) begin
        if (rhist[k] != ALL_ONES) rhist[k] <= rhist[k] + 1;
        if (ev.dur > rmax) rmax <= ev.dur;
        if (ev.dur < rmin) rmin <= ev.dur;
        rsum <= ({1'b0, rsum} + {1'b0, ev.dur} > {1'b0, ALL_ONES}) ? ALL_ONES :
                rsum + ev.dur;
        if (runs != ALL_ONES) runs <= runs + 1;
      end
      if (ev.rec_wait) begin
        if (whist[k] != ALL_ONES) whist[k] <= whist[k] + 1;
        if (ev.dur > wmax) wmax <= ev.dur;
        if (ev.dur < wmin) wmin <= ev.dur;
        wsum <= ({1'b0, wsum} + {1'b0, ev.dur} > {1'b0, ALL_ONES}) ? ALL_ONES :
                wsum + ev.dur;
        if (waits != ALL_ONES) waits <= waits + 1;
      end
    end
  end

  // datapath of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ev <= q_data; k <= '0; phase <= 1'b0;
      end
      ST_BKT: if (state_next == ST_BKT) k <= k + 1'b1;
      ST_MED_INIT: begin
        k <= '0; upper <= '0; lower <= '0; m <= cnt_m >> 1;
        if (cnt_m == 0) med <= smin;
        else med <= 32'(({1'b0, smin} + {1'b0, smax}) >> 1);
      end
      ST_MED_SCAN: begin
        den <= hk;
        if (upper + {1'b0, hk} >= {1'b0, m}) begin
          lower <= upper;
        end else if (32'(k) + 1 >= NUM_BUCKETS) begin
          lower <= upper;
        end else begin
          upper <= upper + {1'b0, hk};
          k <= k + 1'b1;
        end
        lo <= (k == 0) ? ((smin > 0) ? smin : 32'd0) :
              ((smin > bnd(k - 1'b1)) ? smin : bnd(k - 1'b1));
        hi <= (smax < bnd(k)) ? smax : bnd(k);
      end
      ST_MED_MUL: begin
        med <= lo;
        prod <= 64'(hi - lo) * 64'(((33'({1'b0, m}) - lower > {1'b0, den}) ? den :
                32'(33'({1'b0, m}) - lower)));
        rem <= '0; rem_q <= '0; step <= '0;
      end
      ST_MED_DIV: begin
        // restoring division, one quotient bit a cycle; quotient fits 32 bits
        if ({rem[31:0], prod[63]} >= {1'b0, den}) begin
          rem <= {rem[31:0], prod[63]} - {1'b0, den};
          rem_q <= {rem_q[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], prod[63]};
          rem_q <= {rem_q[62:0], 1'b0};
        end
        prod <= {prod[62:0], 1'b0};
        step <= step + 1'b1;
        if (step == 6'd63)
          med <= lo + (({rem[31:0], prod[63]} >= {1'b0, den}) ?
                 {rem_q[30:0], 1'b1} : {rem_q[30:0], 1'b0});
      end
      ST_MED_DONE: begin
        if (!phase) run_med <= med;
        phase <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_data.run_count   = runs;
    res_data.run_sum     = rsum;
    res_data.run_min     = rmin;
    res_data.run_max     = rmax;
    res_data.run_median  = run_med;
    res_data.wait_sum    = wsum;
    res_data.wait_min    = wmin;
    res_data.wait_max    = wmax;
    res_data.wait_median = med;
    res_data.run_bucket_count  = (32'(ev.sel) < NUM_BUCKETS) ? rhist[ev.sel[BKT_W-1:0]] : '0;
    res_data.wait_bucket_count = (32'(ev.sel) < NUM_BUCKETS) ? whist[ev.sel[BKT_W-1:0]] : '0;
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE) else $error("pop outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    runs != 0 |-> rmin <= rmax) else $error("run min above max");
endmodule

/* rtl/duration_histogram_stats_top.sv */
// sequence from input accept to result valid: bucket walk, statistics update, then
// each median, run then wait, goes straight to done when its count is two or less,
// otherwise a bucket scan plus a restoring divide unless the bucket or its clipped span is empty
// flow: the back takes a new item only once the last result is taken; one item in the
// back at a time, two queued ahead
// reset: synchronous, clears statistics, histograms and timestamps, loads bounds
// depends on dhs_pkg, dhs_if, dhs_front, dhs_queue, dhs_back
module duration_histogram_stats_top (
  input  logic        clk,
  input  logic        rst,
  dhs_if.sink         in_ch,
  dhs_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);
  import dhs_pkg::*;

  logic q_push, q_full, q_pop, q_ne;
  evt_t q_w, q_r;

  dhs_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.data.operation), .in_ts(in_ch.data.timestamp_us),
    .in_sel(in_ch.data.bucket_index),
    .q_push, .q_data(q_w), .q_full
  );

  dhs_queue u_queue (
    .clk, .rst, .push(q_push), .wdata(q_w), .full(q_full),
    .pop(q_pop), .rdata(q_r), .nonempty(q_ne)
  );

  dhs_back u_back (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .q_nonempty(q_ne), .q_data(q_r), .q_pop,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_data(out_ch.data)
  );
endmodule
